@@ sv/hst_pkg.sv @@
// hst_pkg: shared types, codes and helpers for the heating sequence thermostat core
// no dependencies; used by heating_sequence_thermostat_core
`timescale 1ns / 1ps
`default_nettype none

package hst_pkg;

    // field widths
    localparam int unsigned OP_W    = 3;
    localparam int unsigned TEMP_W  = 12;
    localparam int unsigned LIMIT_W = 11;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned CFG_A_W = 2;
    localparam int unsigned N_MODES = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_ARM    = 3'd1;
    localparam logic [OP_W-1:0] OP_CANCEL = 3'd2;
    localparam logic [OP_W-1:0] OP_START  = 3'd3;
    localparam logic [OP_W-1:0] OP_PREV   = 3'd4;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_COOK_LOW  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_COOK_HIGH = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_PROBE_END = 2'd2;

    // register reset values, tenths of a degree
    localparam logic [LIMIT_W-1:0] COOK_LOW_RST  = 11'd700;
    localparam logic [LIMIT_W-1:0] COOK_HIGH_RST = 11'd800;
    localparam logic [LIMIT_W-1:0] PROBE_END_RST = 11'd720;

    // rise over baseline that starts heating (5 degrees)
    localparam logic signed [TEMP_W:0] RISE_THRESHOLD = 13'sd50;

    // mode codes as seen on the result beat
    localparam logic [CODE_W-1:0] CODE_STOP    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_HEAT    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_COOKING = 3'd2;
    localparam logic [CODE_W-1:0] CODE_CANCEL  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_END     = 3'd4;

    // stamp table slots
    localparam int unsigned IDX_STOP    = 0;
    localparam int unsigned IDX_HEAT    = 1;
    localparam int unsigned IDX_COOKING = 2;
    localparam int unsigned IDX_CANCEL  = 3;
    localparam int unsigned IDX_END     = 4;

    // mode state, one-hot
    typedef enum logic [N_MODES-1:0] {
        MODE_STOP    = 5'b00001,
        MODE_HEAT    = 5'b00010,
        MODE_COOKING = 5'b00100,
        MODE_CANCEL  = 5'b01000,
        MODE_END     = 5'b10000
    } mode_t;

    typedef logic [TIME_W-1:0] stamp_t;

    // one-hot mode to output code
    function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
        logic [CODE_W-1:0] c;
        case (m)
            MODE_STOP:    c = CODE_STOP;
            MODE_HEAT:    c = CODE_HEAT;
            MODE_COOKING: c = CODE_COOKING;
            MODE_CANCEL:  c = CODE_CANCEL;
            default:      c = CODE_END;
        endcase
        return c;
    endfunction

    // unsigned limit as a signed value for comparison with a temperature
    function automatic logic signed [TEMP_W:0] limit_s(input logic [LIMIT_W-1:0] lim);
        return $signed({2'b00, lim});
    endfunction

    // seconds since a stamp, zero when never stamped
    function automatic stamp_t since(input stamp_t stamp, input stamp_t now);
        return (stamp == '0) ? '0 : now - stamp;
    endfunction

endpackage

`default_nettype wire

@@ sv/heating_sequence_thermostat_core.sv @@
// heating_sequence_thermostat_core: mode sequencer, heater hysteresis and mode timers
// depends on hst_pkg
`timescale 1ns / 1ps
`default_nettype none

//  channel  | direction | payload                                        | handshake
//  ---------+-----------+------------------------------------------------+----------------
//  s_       | in        | operation, vessel_temp, probe_temp, time_now   | valid / ready
//  m_       | out       | mode, heater, disabled, mode_elapsed, cook_el. | valid / ready
//  cfg_     | in        | cook low / cook high / probe end limits        | write enable
//
//  one beat is accepted per clock while s_ready is high; its result appears on m_ in the next cycle
//  the update logic and the result register sit in a single stage
//  s_ready is low only while a result is held and m_ready is low
//  aresetn (synchronous) resets mode to stop, clears heater, disabled, baseline, stamps; limits load reset values

module heating_sequence_thermostat_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input beats
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [hst_pkg::OP_W-1:0]         s_operation,
    input  wire logic signed [hst_pkg::TEMP_W-1:0] s_vessel_temp,
    input  wire logic signed [hst_pkg::TEMP_W-1:0] s_probe_temp,
    input  wire logic [hst_pkg::TIME_W-1:0]       s_time_now,
    // result beats
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [hst_pkg::CODE_W-1:0]            m_mode,
    output logic                                  m_heater,
    output logic                                  m_disabled,
    output logic [hst_pkg::TIME_W-1:0]            m_mode_elapsed,
    output logic [hst_pkg::TIME_W-1:0]            m_cooking_elapsed,
    // configuration writes
    input  wire logic                             cfg_we,
    input  wire logic [hst_pkg::CFG_A_W-1:0]      cfg_addr,
    input  wire logic [hst_pkg::LIMIT_W-1:0]      cfg_wdata
);

    // limit registers
    logic [hst_pkg::LIMIT_W-1:0] cook_low_reg;
    logic [hst_pkg::LIMIT_W-1:0] cook_high_reg;
    logic [hst_pkg::LIMIT_W-1:0] probe_end_reg;

    // controller state
    hst_pkg::mode_t                   mode_reg, mode_next;
    logic                             heater_reg, heater_next;
    logic                             disabled_reg, disabled_next;
    logic signed [hst_pkg::TEMP_W-1:0] baseline_reg, baseline_next;
    hst_pkg::stamp_t                  stamp_reg  [hst_pkg::N_MODES];
    hst_pkg::stamp_t                  stamp_next [hst_pkg::N_MODES];

    // result register
    logic                             m_valid_reg;
    logic [hst_pkg::CODE_W-1:0]       m_mode_reg;
    logic                             m_heater_reg;
    logic                             m_disabled_reg;
    hst_pkg::stamp_t                  m_mode_elapsed_reg, m_mode_elapsed_next;
    hst_pkg::stamp_t                  m_cooking_elapsed_reg;

    logic                             s_accept;
    logic                             run_service;
    logic signed [hst_pkg::TEMP_W:0]  vessel_x;
    logic signed [hst_pkg::TEMP_W:0]  probe_x;
    logic signed [hst_pkg::TEMP_W:0]  rise;

    // result register frees up when taken or empty
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign vessel_x = {s_vessel_temp[hst_pkg::TEMP_W-1], s_vessel_temp};
    assign probe_x  = {s_probe_temp[hst_pkg::TEMP_W-1], s_probe_temp};
    assign rise     = vessel_x - {baseline_reg[hst_pkg::TEMP_W-1], baseline_reg};

    // command decode, then one service step unless the command or the disabled flag suppresses it
    always_comb begin
        mode_next     = mode_reg;
        heater_next   = heater_reg;
        disabled_next = disabled_reg;
        baseline_next = baseline_reg;
        stamp_next    = stamp_reg;
        run_service   = 1'b1;

        case (s_operation)
            hst_pkg::OP_ARM: begin
                mode_next                     = hst_pkg::MODE_STOP;
                stamp_next[hst_pkg::IDX_STOP] = s_time_now;
                baseline_next                 = s_vessel_temp;
                heater_next                   = 1'b0;
                run_service                   = 1'b0;
            end
            hst_pkg::OP_CANCEL: begin
                if (mode_reg == hst_pkg::MODE_CANCEL) begin
                    disabled_next = 1'b1;
                end else begin
                    mode_next = hst_pkg::MODE_CANCEL;
                end
            end
            hst_pkg::OP_START: begin
                if (mode_reg == hst_pkg::MODE_STOP || mode_reg == hst_pkg::MODE_CANCEL ||
                    mode_reg == hst_pkg::MODE_END) begin
                    mode_next = hst_pkg::MODE_HEAT;
                end
            end
            hst_pkg::OP_PREV: begin
                case (mode_reg)
                    hst_pkg::MODE_HEAT:    mode_next = hst_pkg::MODE_STOP;
                    hst_pkg::MODE_COOKING: mode_next = hst_pkg::MODE_HEAT;
                    hst_pkg::MODE_END:     mode_next = hst_pkg::MODE_COOKING;
                    default:               mode_next = mode_reg;
                endcase
            end
            hst_pkg::OP_NEXT: begin
                case (mode_reg)
                    hst_pkg::MODE_STOP:    mode_next = hst_pkg::MODE_HEAT;
                    hst_pkg::MODE_HEAT:    mode_next = hst_pkg::MODE_COOKING;
                    hst_pkg::MODE_COOKING: mode_next = hst_pkg::MODE_END;
                    default:               mode_next = mode_reg;
                endcase
            end
            default: begin
                // tick and unused codes: service only while enabled
                run_service = !disabled_reg;
            end
        endcase

        if (run_service) begin
            case (mode_next)
                hst_pkg::MODE_STOP: begin
                    if (rise > hst_pkg::RISE_THRESHOLD) begin
                        mode_next = hst_pkg::MODE_HEAT;
                        if (stamp_next[hst_pkg::IDX_HEAT] == '0) begin
                            stamp_next[hst_pkg::IDX_HEAT] = s_time_now;
                        end
                    end
                end
                hst_pkg::MODE_HEAT: begin
                    heater_next = 1'b1;
                    if (vessel_x > hst_pkg::limit_s(cook_low_reg)) begin
                        mode_next = hst_pkg::MODE_COOKING;
                        if (stamp_next[hst_pkg::IDX_COOKING] == '0) begin
                            stamp_next[hst_pkg::IDX_COOKING] = s_time_now;
                        end
                    end
                end
                hst_pkg::MODE_COOKING: begin
                    // hysteresis: low limit wins when both hold
                    if (vessel_x >= hst_pkg::limit_s(cook_high_reg)) begin
                        heater_next = 1'b0;
                    end
                    if (vessel_x <= hst_pkg::limit_s(cook_low_reg)) begin
                        heater_next = 1'b1;
                    end
                    if (probe_x >= hst_pkg::limit_s(probe_end_reg)) begin
                        mode_next                    = hst_pkg::MODE_END;
                        stamp_next[hst_pkg::IDX_END] = s_time_now;
                    end
                end
                default: begin
                    heater_next = 1'b0;
                end
            endcase
        end
    end

    // elapsed time of the mode reached
    always_comb begin
        case (mode_next)
            hst_pkg::MODE_STOP:
                m_mode_elapsed_next = hst_pkg::since(stamp_next[hst_pkg::IDX_STOP], s_time_now);
            hst_pkg::MODE_HEAT:
                m_mode_elapsed_next = hst_pkg::since(stamp_next[hst_pkg::IDX_HEAT], s_time_now);
            hst_pkg::MODE_COOKING:
                m_mode_elapsed_next =
                    hst_pkg::since(stamp_next[hst_pkg::IDX_COOKING], s_time_now);
            hst_pkg::MODE_CANCEL:
                m_mode_elapsed_next =
                    hst_pkg::since(stamp_next[hst_pkg::IDX_CANCEL], s_time_now);
            default:
                m_mode_elapsed_next = hst_pkg::since(stamp_next[hst_pkg::IDX_END], s_time_now);
        endcase
    end

    // limit register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cook_low_reg  <= hst_pkg::COOK_LOW_RST;
            cook_high_reg <= hst_pkg::COOK_HIGH_RST;
            probe_end_reg <= hst_pkg::PROBE_END_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                hst_pkg::REG_COOK_LOW:  cook_low_reg  <= cfg_wdata;
                hst_pkg::REG_COOK_HIGH: cook_high_reg <= cfg_wdata;
                hst_pkg::REG_PROBE_END: probe_end_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // controller state update per accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= hst_pkg::MODE_STOP;
            heater_reg   <= 1'b0;
            disabled_reg <= 1'b0;
            baseline_reg <= '0;
            for (int i = 0; i < hst_pkg::N_MODES; i++) begin
                stamp_reg[i] <= '0;
            end
        end else if (s_accept) begin
            mode_reg     <= mode_next;
            heater_reg   <= heater_next;
            disabled_reg <= disabled_next;
            baseline_reg <= baseline_next;
            stamp_reg    <= stamp_next;
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_mode_reg            <= hst_pkg::mode_code(mode_next);
            m_heater_reg          <= heater_next;
            m_disabled_reg        <= disabled_next;
            m_mode_elapsed_reg    <= m_mode_elapsed_next;
            m_cooking_elapsed_reg <=
                hst_pkg::since(stamp_next[hst_pkg::IDX_COOKING], s_time_now);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_mode            = m_mode_reg;
    assign m_heater          = m_heater_reg;
    assign m_disabled        = m_disabled_reg;
    assign m_mode_elapsed    = m_mode_elapsed_reg;
    assign m_cooking_elapsed = m_cooking_elapsed_reg;

endmodule

`default_nettype wire
